// File: rtl/core/stsub_pkg.sv
`timescale 1ns / 1ps
package stsub_pkg;

    localparam int COORD_W = 24;
    localparam int ID_W    = 16;
    localparam int CFG_W   = 16;

    // microcode lengths and record count
    localparam int CORNER_LEN = 18;
    localparam int POINT_LEN  = 20;
    localparam int N_REC      = 10;

    localparam logic signed [31:0] HALF_PI_Q28  = 32'sd421657428;
    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;
    // ceil(2^33 / 3), exact floor(m / 3) for m below 2^32
    localparam logic [33:0]        DIV3_RECIP   = 34'h0AAAAAAAB;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
        logic        [ID_W-1:0]    a_id;
        logic        [ID_W-1:0]    b_id;
        logic        [ID_W-1:0]    c_id;
    } t_in_item;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] new_x;
        logic signed [COORD_W-1:0] new_y;
        logic signed [COORD_W-1:0] new_z;
        logic        [ID_W-1:0]    point_id;
        logic        [ID_W-1:0]    corner_first;
        logic        [ID_W-1:0]    corner_second;
        logic        [ID_W-1:0]    corner_third;
        logic                      last_of_run;
    } t_out_item;

    typedef enum logic [5:0] {
        OP_NONE, OP_LOAD, OP_WAIT,
        OP_MUL_XX, OP_WB_XX, OP_MUL_YY, OP_WB_YY, OP_MUL_ZZ, OP_WB_ZZ,
        OP_SQRT_R, OP_WB_R, OP_SQRT_RHO, OP_WB_RHO,
        OP_VEC_TH, OP_WB_TH, OP_VEC_PH, OP_WB_PH,
        OP_MUL_AR, OP_WB_AR, OP_MUL_AT, OP_WB_AT, OP_MUL_AP, OP_WB_AP,
        OP_ROT_T, OP_WB_T, OP_ROT_P, OP_WB_P,
        OP_MUL_RC, OP_WB_RC, OP_MUL_NX, OP_WB_NX,
        OP_MUL_NY, OP_WB_NY, OP_MUL_NZ, OP_WB_NZ
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE, S_CORNER, S_POINT, S_EMIT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [1:0] idx;
        logic [3:0] rec;
    } t_dp_cmd;

    typedef struct packed {
        logic sqrt_busy;
        logic cordic_busy;
    } t_dp_stat;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459457;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            5'd24:   v = 32'sd16;
            5'd25:   v = 32'sd8;
            5'd26:   v = 32'sd4;
            5'd27:   v = 32'sd2;
            5'd28:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic t_op corner_op(input logic [4:0] pc);
        t_op op;
        case (pc)
            5'd0:    op = OP_MUL_XX;
            5'd1:    op = OP_WB_XX;
            5'd2:    op = OP_MUL_YY;
            5'd3:    op = OP_WB_YY;
            5'd4:    op = OP_MUL_ZZ;
            5'd5:    op = OP_WB_ZZ;
            5'd6:    op = OP_SQRT_R;
            5'd7:    op = OP_WAIT;
            5'd8:    op = OP_WB_R;
            5'd9:    op = OP_SQRT_RHO;
            5'd10:   op = OP_WAIT;
            5'd11:   op = OP_WB_RHO;
            5'd12:   op = OP_VEC_TH;
            5'd13:   op = OP_WAIT;
            5'd14:   op = OP_WB_TH;
            5'd15:   op = OP_VEC_PH;
            5'd16:   op = OP_WAIT;
            5'd17:   op = OP_WB_PH;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic t_op point_op(input logic [4:0] pc);
        t_op op;
        case (pc)
            5'd0:    op = OP_MUL_AR;
            5'd1:    op = OP_WB_AR;
            5'd2:    op = OP_MUL_AT;
            5'd3:    op = OP_WB_AT;
            5'd4:    op = OP_MUL_AP;
            5'd5:    op = OP_WB_AP;
            5'd6:    op = OP_ROT_T;
            5'd7:    op = OP_WAIT;
            5'd8:    op = OP_WB_T;
            5'd9:    op = OP_ROT_P;
            5'd10:   op = OP_WAIT;
            5'd11:   op = OP_WB_P;
            5'd12:   op = OP_MUL_RC;
            5'd13:   op = OP_WB_RC;
            5'd14:   op = OP_MUL_NX;
            5'd15:   op = OP_WB_NX;
            5'd16:   op = OP_MUL_NY;
            5'd17:   op = OP_WB_NY;
            5'd18:   op = OP_MUL_NZ;
            5'd19:   op = OP_WB_NZ;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

// File: rtl/core/stsub_sqrt.sv
`timescale 1ns / 1ps
module stsub_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_v,
    output logic        o_busy,
    output logic [23:0] o_root
);
    import stsub_pkg::*;

    logic        r_busy;
    logic [47:0] r_v;
    logic [47:0] r_res;
    logic [47:0] r_bit;
    logic [47:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
        end
    end

    // one result bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_v;
            r_res <= '0;
            r_bit <= 48'(1) << 46;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[23:0];

endmodule

// File: rtl/core/stsub_cordic.sv
`timescale 1ns / 1ps
module stsub_cordic #(
    parameter int ITER = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_vec,
    input  logic signed [24:0] i_vx,
    input  logic signed [24:0] i_vy,
    input  logic signed [31:0] i_ang,
    output logic               o_busy,
    output logic signed [31:0] o_ang,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    import stsub_pkg::*;

    logic               r_busy;
    logic [5:0]         r_cnt;
    logic               r_vec;
    logic signed [43:0] r_x;
    logic signed [43:0] r_y;
    logic signed [31:0] r_a;

    logic signed [43:0] sx, sy, dx, dy, inv;
    logic               zero_vec, up;

    assign sx       = {{3{i_vx[24]}}, i_vx, 16'b0};
    assign sy       = {{3{i_vy[24]}}, i_vy, 16'b0};
    assign zero_vec = (i_vx == '0) && (i_vy == '0);
    assign inv      = 44'(INV_GAIN_Q30);
    assign dx       = r_y >>> r_cnt[4:0];
    assign dy       = r_x >>> r_cnt[4:0];
    // vectoring drives y to zero, rotation drives the angle to zero
    assign up       = r_vec ? ~r_y[43] : r_a[31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !(i_vec && zero_vec);
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 6'(ITER - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_vec <= i_vec;
            if (i_vec) begin
                if (zero_vec) begin
                    r_x <= '0;
                    r_y <= '0;
                    r_a <= '0;
                end else if (sx < 0 && sy >= 0) begin
                    r_x <= sy;
                    r_y <= -sx;
                    r_a <= HALF_PI_Q28;
                end else if (sx < 0) begin
                    r_x <= -sy;
                    r_y <= sx;
                    r_a <= -HALF_PI_Q28;
                end else begin
                    r_x <= sx;
                    r_y <= sy;
                    r_a <= '0;
                end
            end else begin
                if (i_ang > HALF_PI_Q28) begin
                    r_x <= '0;
                    r_y <= inv;
                    r_a <= i_ang - HALF_PI_Q28;
                end else if (i_ang < -HALF_PI_Q28) begin
                    r_x <= '0;
                    r_y <= -inv;
                    r_a <= i_ang + HALF_PI_Q28;
                end else begin
                    r_x <= inv;
                    r_y <= '0;
                    r_a <= i_ang;
                end
            end
        end else if (r_busy) begin
            if (up) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_a <= r_a + atan_q28(r_cnt[4:0]);
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_a <= r_a - atan_q28(r_cnt[4:0]);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_ang  = r_a;
    assign o_cos  = r_x[33:0];
    assign o_sin  = r_y[33:0];

endmodule

// File: rtl/core/stsub_ctrl.sv
`timescale 1ns / 1ps
module stsub_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  stsub_pkg::t_dp_stat i_stat,
    output stsub_pkg::t_dp_cmd  o_cmd
);
    import stsub_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_pc, n_pc;
    logic [1:0] r_idx, n_idx;
    logic [3:0] r_rec, n_rec;
    logic       busy;
    t_op        op;

    assign busy = i_stat.sqrt_busy | i_stat.cordic_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_idx   <= '0;
            r_rec   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_idx   <= n_idx;
            r_rec   <= n_rec;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_idx   = r_idx;
        n_rec   = r_rec;
        op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = S_CORNER;
                    n_pc    = '0;
                    n_idx   = '0;
                end
            end
            S_CORNER: begin
                op = corner_op(r_pc);
                if (!(op == OP_WAIT && busy)) begin
                    if (r_pc == 5'(CORNER_LEN - 1)) begin
                        n_pc = '0;
                        if (r_idx == 2'd2) begin
                            n_idx   = '0;
                            n_state = S_POINT;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end else begin
                        n_pc = r_pc + 5'd1;
                    end
                end
            end
            S_POINT: begin
                op = point_op(r_pc);
                if (!(op == OP_WAIT && busy)) begin
                    if (r_pc == 5'(POINT_LEN - 1)) begin
                        n_pc = '0;
                        if (r_idx == 2'd3) begin
                            n_idx   = '0;
                            n_rec   = '0;
                            n_state = S_EMIT;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end else begin
                        n_pc = r_pc + 5'd1;
                    end
                end
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    if (r_rec == 4'(N_REC - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rec = r_rec + 4'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd.op    = op;
    assign o_cmd.idx   = r_idx;
    assign o_cmd.rec   = r_rec;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

endmodule

// File: rtl/core/stsub_dp.sv
`timescale 1ns / 1ps
module stsub_dp #(
    parameter int ITER = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  stsub_pkg::t_dp_cmd     i_cmd,
    output stsub_pkg::t_dp_stat    o_stat,
    input  stsub_pkg::t_in_item    i_in_data,
    input  logic                   i_cfg_wr_en,
    input  logic [stsub_pkg::CFG_W-1:0] i_cfg_wr_data,
    output stsub_pkg::t_out_item   o_out_data
);
    import stsub_pkg::*;

    localparam logic signed [37:0] SAT_HI = (38'sd1 <<< (COORD_W - 1)) - 38'sd1;
    localparam logic signed [37:0] SAT_LO = -SAT_HI - 38'sd1;

    function automatic logic signed [37:0] round30(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = p + 68'sd536870912;
        return t[67:30];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [37:0] v);
        logic signed [37:0] t;
        t = v;
        if (v > SAT_HI) t = SAT_HI;
        if (v < SAT_LO) t = SAT_LO;
        return t[COORD_W-1:0];
    endfunction

    // halve, truncating toward zero
    function automatic logic signed [31:0] half_tz(input logic signed [32:0] s);
        logic signed [33:0] t;
        t = 34'(s) + $signed({33'b0, s[32]});
        return t[32:1];
    endfunction

    logic signed [COORD_W-1:0] r_cx [3];
    logic signed [COORD_W-1:0] r_cy [3];
    logic signed [COORD_W-1:0] r_cz [3];
    logic [ID_W-1:0]           r_cid [3];
    logic [ID_W-1:0]           r_base;
    logic [ID_W-1:0]           r_next_id;

    logic signed [67:0]        r_prod;
    logic [46:0]               r_xx, r_yy, r_zz;
    logic [23:0]               r_rad [3];
    logic [23:0]               r_rho;
    logic signed [31:0]        r_th [3];
    logic signed [31:0]        r_ph [3];

    logic [23:0]               r_pr;
    logic signed [31:0]        r_pt, r_pp;
    logic signed [33:0]        r_ct, r_st, r_cp, r_sp;
    logic signed [25:0]        r_rc;
    logic signed [COORD_W-1:0] r_ox [4];
    logic signed [COORD_W-1:0] r_oy [4];
    logic signed [COORD_W-1:0] r_oz [4];

    logic signed [COORD_W-1:0] x_k, y_k, z_k;
    logic signed [33:0]        mul_a, mul_b;
    logic [25:0]               rsum3;
    logic signed [33:0]        tsum3, psum3;
    logic [33:0]               tmag3, pmag3;
    logic [24:0]               rsum2;
    logic signed [32:0]        tsum2, psum2;
    logic [1:0]                ia, ib;
    logic [31:0]               q_t, q_p;

    logic                      sq_start, sq_busy;
    logic [47:0]               sq_v;
    logic [23:0]               sq_root;
    logic                      co_start, co_vec, co_busy;
    logic signed [24:0]        co_vx, co_vy;
    logic signed [31:0]        co_ang_in, co_ang;
    logic signed [33:0]        co_cos, co_sin;
    logic [3:0]                tri_n;

    assign x_k = r_cx[i_cmd.idx];
    assign y_k = r_cy[i_cmd.idx];
    assign z_k = r_cz[i_cmd.idx];

    assign rsum3 = 26'(r_rad[0]) + 26'(r_rad[1]) + 26'(r_rad[2]);
    assign tsum3 = 34'(r_th[0]) + 34'(r_th[1]) + 34'(r_th[2]);
    assign psum3 = 34'(r_ph[0]) + 34'(r_ph[1]) + 34'(r_ph[2]);
    assign tmag3 = tsum3[33] ? 34'(-tsum3) : 34'(tsum3);
    assign pmag3 = psum3[33] ? 34'(-psum3) : 34'(psum3);

    // corner pair of each edge midpoint
    always_comb begin
        case (i_cmd.idx)
            2'd1: begin
                ia = 2'd0;
                ib = 2'd1;
            end
            2'd2: begin
                ia = 2'd1;
                ib = 2'd2;
            end
            default: begin
                ia = 2'd0;
                ib = 2'd2;
            end
        endcase
    end

    assign rsum2 = 25'(r_rad[ia]) + 25'(r_rad[ib]);
    assign tsum2 = 33'(r_th[ia]) + 33'(r_th[ib]);
    assign psum2 = 33'(r_ph[ia]) + 33'(r_ph[ib]);
    assign q_t   = r_prod[64:33];
    assign q_p   = r_prod[64:33];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MUL_XX: begin
                mul_a = 34'(x_k);
                mul_b = 34'(x_k);
            end
            OP_MUL_YY: begin
                mul_a = 34'(y_k);
                mul_b = 34'(y_k);
            end
            OP_MUL_ZZ: begin
                mul_a = 34'(z_k);
                mul_b = 34'(z_k);
            end
            OP_MUL_AR: begin
                mul_a = $signed({8'b0, rsum3});
                mul_b = $signed(DIV3_RECIP);
            end
            OP_MUL_AT: begin
                mul_a = $signed(tmag3);
                mul_b = $signed(DIV3_RECIP);
            end
            OP_MUL_AP: begin
                mul_a = $signed(pmag3);
                mul_b = $signed(DIV3_RECIP);
            end
            OP_MUL_RC: begin
                mul_a = $signed({10'b0, r_pr});
                mul_b = r_cp;
            end
            OP_MUL_NX: begin
                mul_a = 34'(r_rc);
                mul_b = r_ct;
            end
            OP_MUL_NY: begin
                mul_a = $signed({10'b0, r_pr});
                mul_b = r_sp;
            end
            OP_MUL_NZ: begin
                mul_a = 34'(r_rc);
                mul_b = r_st;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sq_start = (i_cmd.op == OP_SQRT_R) || (i_cmd.op == OP_SQRT_RHO);
    assign sq_v     = (i_cmd.op == OP_SQRT_R) ? 48'(r_xx) + 48'(r_yy) + 48'(r_zz)
                                              : 48'(r_xx) + 48'(r_zz);

    assign co_start  = (i_cmd.op == OP_VEC_TH) || (i_cmd.op == OP_VEC_PH)
                    || (i_cmd.op == OP_ROT_T) || (i_cmd.op == OP_ROT_P);
    assign co_vec    = (i_cmd.op == OP_VEC_TH) || (i_cmd.op == OP_VEC_PH);
    assign co_vx     = (i_cmd.op == OP_VEC_PH) ? $signed({1'b0, r_rho}) : 25'(x_k);
    assign co_vy     = (i_cmd.op == OP_VEC_PH) ? 25'(y_k) : 25'(z_k);
    assign co_ang_in = (i_cmd.op == OP_ROT_P) ? r_pp : r_pt;

    stsub_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_v     (sq_v),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    stsub_cordic #(
        .ITER (ITER)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (co_start),
        .i_vec   (co_vec),
        .i_vx    (co_vx),
        .i_vy    (co_vy),
        .i_ang   (co_ang_in),
        .o_busy  (co_busy),
        .o_ang   (co_ang),
        .o_cos   (co_cos),
        .o_sin   (co_sin)
    );

    assign o_stat.sqrt_busy   = sq_busy;
    assign o_stat.cordic_busy = co_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id <= '0;
        end else if (i_cmd.op == OP_LOAD) begin
            r_next_id <= r_next_id + ID_W'(4);
        end else if (i_cfg_wr_en) begin
            r_next_id <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            OP_LOAD: begin
                r_cx[0]  <= i_in_data.a_x;
                r_cy[0]  <= i_in_data.a_y;
                r_cz[0]  <= i_in_data.a_z;
                r_cx[1]  <= i_in_data.b_x;
                r_cy[1]  <= i_in_data.b_y;
                r_cz[1]  <= i_in_data.b_z;
                r_cx[2]  <= i_in_data.c_x;
                r_cy[2]  <= i_in_data.c_y;
                r_cz[2]  <= i_in_data.c_z;
                r_cid[0] <= i_in_data.a_id;
                r_cid[1] <= i_in_data.b_id;
                r_cid[2] <= i_in_data.c_id;
                r_base   <= r_next_id;
            end
            OP_WB_XX:  r_xx <= r_prod[46:0];
            OP_WB_YY:  r_yy <= r_prod[46:0];
            OP_WB_ZZ:  r_zz <= r_prod[46:0];
            OP_WB_R:   r_rad[i_cmd.idx] <= sq_root;
            OP_WB_RHO: r_rho <= sq_root;
            OP_WB_TH:  r_th[i_cmd.idx] <= co_ang;
            OP_WB_PH:  r_ph[i_cmd.idx] <= co_ang;
            OP_WB_AR: begin
                if (i_cmd.idx == 2'd0) begin
                    r_pr <= r_prod[56:33];
                end else begin
                    r_pr <= rsum2[24:1];
                end
            end
            OP_WB_AT: begin
                if (i_cmd.idx == 2'd0) begin
                    r_pt <= tsum3[33] ? -$signed(q_t) : $signed(q_t);
                end else begin
                    r_pt <= half_tz(tsum2);
                end
            end
            OP_WB_AP: begin
                if (i_cmd.idx == 2'd0) begin
                    r_pp <= psum3[33] ? -$signed(q_p) : $signed(q_p);
                end else begin
                    r_pp <= half_tz(psum2);
                end
            end
            OP_WB_T: begin
                r_ct <= co_cos;
                r_st <= co_sin;
            end
            OP_WB_P: begin
                r_cp <= co_cos;
                r_sp <= co_sin;
            end
            OP_WB_RC: r_rc <= 26'(round30(r_prod));
            OP_WB_NX: r_ox[i_cmd.idx] <= sat(round30(r_prod));
            OP_WB_NY: r_oy[i_cmd.idx] <= sat(round30(r_prod));
            OP_WB_NZ: r_oz[i_cmd.idx] <= sat(round30(r_prod));
            default: begin
            end
        endcase
    end

    assign tri_n = i_cmd.rec - 4'd4;

    // four point records, then six triangles around the centre
    always_comb begin
        o_out_data = '0;
        o_out_data.last_of_run = (i_cmd.rec == 4'(N_REC - 1));
        if (i_cmd.rec < 4'd4) begin
            o_out_data.kind     = 1'b0;
            o_out_data.new_x    = r_ox[i_cmd.rec[1:0]];
            o_out_data.new_y    = r_oy[i_cmd.rec[1:0]];
            o_out_data.new_z    = r_oz[i_cmd.rec[1:0]];
            o_out_data.point_id = r_base + ID_W'(i_cmd.rec);
        end else begin
            o_out_data.kind         = 1'b1;
            o_out_data.corner_first = r_base;
            case (tri_n)
                4'd0: begin
                    o_out_data.corner_second = r_base + ID_W'(1);
                    o_out_data.corner_third  = r_cid[0];
                end
                4'd1: begin
                    o_out_data.corner_second = r_base + ID_W'(1);
                    o_out_data.corner_third  = r_cid[1];
                end
                4'd2: begin
                    o_out_data.corner_second = r_base + ID_W'(2);
                    o_out_data.corner_third  = r_cid[1];
                end
                4'd3: begin
                    o_out_data.corner_second = r_base + ID_W'(2);
                    o_out_data.corner_third  = r_cid[2];
                end
                4'd4: begin
                    o_out_data.corner_second = r_base + ID_W'(3);
                    o_out_data.corner_third  = r_cid[0];
                end
                default: begin
                    o_out_data.corner_second = r_base + ID_W'(3);
                    o_out_data.corner_third  = r_cid[2];
                end
            endcase
        end
    end

endmodule

// File: rtl/core/spherical_triangle_subdivider_core.sv
`timescale 1ns / 1ps
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+--------------------------
// input    | in        | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
// output   | out       | o_out_valid / i_out_stall  | o_out_data (t_out_item)
// config   | in        | i_cfg_wr_en                | i_cfg_wr_data (first id)
//
// one triangle at a time: an accept step, three corner programs and four
// point programs that wait on the serial sqrt unit (six runs per item) and
// the shared cordic (20 steps by default, one step a cycle, fourteen runs
// per item), then ten output records; a zero vector corner skips its
// cordic run
// synchronous active-low reset clears the sequencer, unit busy flags and id
// counter; no clearing pass
// output stall holds the current record; input is stalled until the tenth
// record of the item is taken
module spherical_triangle_subdivider_core #(
    parameter int CORDIC_ITERATIONS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  stsub_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output stsub_pkg::t_out_item          o_out_data,
    input  logic                          i_cfg_wr_en,
    input  logic [stsub_pkg::CFG_W-1:0]   i_cfg_wr_data
);
    import stsub_pkg::*;

    // command from sequencer, unit status back
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // microcode sequencer: per-corner and per-point programs, then emit
    stsub_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // registers, shared multiplier, sqrt and cordic units
    stsub_dp #(
        .ITER (CORDIC_ITERATIONS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_data    (o_out_data)
    );

endmodule

// File: rtl/core/stsub_checker.sv
`timescale 1ns / 1ps
module stsub_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input stsub_pkg::t_out_item o_out_data
);
    import stsub_pkg::*;

    // block goes busy after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // no input taken while records are pending
    a_no_accept_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while emitting");

    // stalled record holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled record changed");

    // run ends after the last record
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_of_run) |=> !o_out_valid)
        else $error("record after last of run");

    // point records carry no triangle ids
    a_point_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.kind) |-> (o_out_data.corner_first == '0
            && o_out_data.corner_second == '0 && o_out_data.corner_third == '0))
        else $error("point record with corner ids");

endmodule

bind spherical_triangle_subdivider_core stsub_checker u_stsub_checker (.*);

// File: dv/tb_spherical_triangle_subdivider_core.sv
`timescale 1ns / 1ps
module tb_spherical_triangle_subdivider_core;
    import stsub_pkg::*;

    localparam int          ITERS     = 20;
    localparam int          TAIL_WAIT = 1200;
    localparam longint      HALF_PI   = 421657428;
    localparam longint      INV_GAIN  = 652032874;
    localparam longint      RND_Q30   = 536870912;
    localparam logic [15:0] REG_FIRST_ID = 16'd0;

    // idle modes for the two channels
    typedef enum int {MODE_SEND_IDLE, MODE_RECV_IDLE, MODE_NO_IDLE} t_mode;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_data;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    spherical_triangle_subdivider_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    t_in_item   tri_queue[$];
    t_out_item  record_queue[$];
    logic [15:0] id_counter;
    int          n_errors;
    t_mode       mode;
    int          hold_cycles;
    logic        send_pause;

    task automatic add_tri(input t_in_item t);
        tri_queue.insert(tri_queue.size(), t);
    endtask

    task automatic add_record(input t_out_item r);
        record_queue.insert(record_queue.size(), r);
    endtask

    function automatic longint shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(input longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint atan_step(input int i);
        longint tab[20];
        tab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
                32768, 16384, 8192, 4096, 2048, 1024, 512};
        return tab[i];
    endfunction

    // cordic vectoring, angle in q28 radians
    function automatic longint vec_angle(input longint x0, input longint y0);
        longint x, y, a, t, dx, dy;
        x = x0 * 65536;
        y = y0 * 65536;
        a = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; a = HALF_PI;
            end else begin
                t = x; x = -y; y = t; a = -HALF_PI;
            end
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; a += atan_step(i);
            end else begin
                x -= dx; y += dy; a -= atan_step(i);
            end
        end
        return a;
    endfunction

    // cordic rotation, cos and sin in q30
    task automatic rotate(input longint a0, output longint c, output longint s);
        longint x, y, a, dx, dy;
        x = INV_GAIN;
        y = 0;
        a = a0;
        if (a > HALF_PI) begin
            x = 0; y = INV_GAIN; a -= HALF_PI;
        end else if (a < -HALF_PI) begin
            x = 0; y = -INV_GAIN; a += HALF_PI;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (a >= 0) begin
                x -= dx; y += dy; a -= atan_step(i);
            end else begin
                x += dx; y -= dy; a += atan_step(i);
            end
        end
        c = x;
        s = y;
    endtask

    function automatic longint mul_q30(input longint v, input longint f);
        return shr(v * f + RND_Q30, 30);
    endfunction

    function automatic logic [23:0] clamp_coord(input longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    task automatic push_point(input longint r, input longint th, input longint ph,
                              input logic [15:0] id);
        longint ct, st, cp, sp, rc;
        t_out_item rec;
        rotate(th, ct, st);
        rotate(ph, cp, sp);
        rc = mul_q30(r, cp);
        rec = '0;
        rec.new_x = clamp_coord(mul_q30(rc, ct));
        rec.new_y = clamp_coord(mul_q30(r, sp));
        rec.new_z = clamp_coord(mul_q30(rc, st));
        rec.point_id = id;
        add_record(rec);
    endtask

    task automatic push_tri(input logic [15:0] p, input logic [15:0] q,
                            input logic [15:0] w, input logic last);
        t_out_item rec;
        rec = '0;
        rec.kind = 1'b1;
        rec.corner_first = p;
        rec.corner_second = q;
        rec.corner_third = w;
        rec.last_of_run = last;
        add_record(rec);
    endtask

    // expected ten records for one triangle
    task automatic predict_split(input t_in_item t);
        longint r[3], th[3], ph[3], x, y, z, xx, zz;
        logic [15:0] c;
        for (int k = 0; k < 3; k++) begin
            case (k)
                0: begin x = t.a_x; y = t.a_y; z = t.a_z; end
                1: begin x = t.b_x; y = t.b_y; z = t.b_z; end
                default: begin x = t.c_x; y = t.c_y; z = t.c_z; end
            endcase
            xx = x * x;
            zz = z * z;
            r[k] = isqrt(xx + y * y + zz);
            th[k] = vec_angle(x, z);
            ph[k] = vec_angle(isqrt(xx + zz), y);
        end
        c = id_counter;
        // sv division truncates toward zero like the spec
        push_point((r[0] + r[1] + r[2]) / 3, (th[0] + th[1] + th[2]) / 3,
                   (ph[0] + ph[1] + ph[2]) / 3, c);
        push_point((r[0] + r[1]) / 2, (th[0] + th[1]) / 2, (ph[0] + ph[1]) / 2, c + 16'd1);
        push_point((r[2] + r[1]) / 2, (th[2] + th[1]) / 2, (ph[2] + ph[1]) / 2, c + 16'd2);
        push_point((r[0] + r[2]) / 2, (th[0] + th[2]) / 2, (ph[0] + ph[2]) / 2, c + 16'd3);
        push_tri(c, c + 16'd1, t.a_id, 1'b0);
        push_tri(c, c + 16'd1, t.b_id, 1'b0);
        push_tri(c, c + 16'd2, t.b_id, 1'b0);
        push_tri(c, c + 16'd2, t.c_id, 1'b0);
        push_tri(c, c + 16'd3, t.a_id, 1'b0);
        push_tri(c, c + 16'd3, t.c_id, 1'b1);
        id_counter = c + 16'd4;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // driver: offers queued items, idles at random per mode
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && in_stall) begin
            // hold payload while stalled
        end else begin
            if (in_valid) begin
                predict_split(in_data);
                void'(tri_queue.pop_front());
            end
            if (tri_queue.size() != 0 && !send_pause &&
                !(mode == MODE_SEND_IDLE && $urandom_range(99) < 11) &&
                !(mode == MODE_RECV_IDLE && $urandom_range(99) < 83)) begin
                in_valid <= 1'b1;
                in_data  <= tri_queue[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stalls at random per mode, or for a long hold
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= (mode == MODE_SEND_IDLE && $urandom_range(99) < 83) ||
                         (mode == MODE_RECV_IDLE && $urandom_range(99) < 11);
        end
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // monitor: compares each taken record with the oldest expectation
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (record_queue.size() == 0) begin
                report_mismatch("record with none expected, kind", longint'(out_data.kind), -1);
            end else begin
                want = record_queue.pop_front();
                if (out_data.kind !== want.kind) report_mismatch("kind", out_data.kind, want.kind);
                if (out_data.new_x !== want.new_x) report_mismatch("new_x", out_data.new_x, want.new_x);
                if (out_data.new_y !== want.new_y) report_mismatch("new_y", out_data.new_y, want.new_y);
                if (out_data.new_z !== want.new_z) report_mismatch("new_z", out_data.new_z, want.new_z);
                if (out_data.point_id !== want.point_id)
                    report_mismatch("point_id", out_data.point_id, want.point_id);
                if (out_data.corner_first !== want.corner_first)
                    report_mismatch("corner_first", out_data.corner_first, want.corner_first);
                if (out_data.corner_second !== want.corner_second)
                    report_mismatch("corner_second", out_data.corner_second, want.corner_second);
                if (out_data.corner_third !== want.corner_third)
                    report_mismatch("corner_third", out_data.corner_third, want.corner_third);
                if (out_data.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", out_data.last_of_run, want.last_of_run);
            end
        end
    end

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(8191)) - 4096);
            3: return 24'($signed($urandom_range(262143)) - 131072);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_tri();
        t_in_item t;
        t = '0;
        t.a_id = 16'($urandom); t.b_id = 16'($urandom); t.c_id = 16'($urandom);
        t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
        t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
        t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
        return t;
    endfunction

    task automatic wait_drained();
        while (tri_queue.size() != 0 || in_valid || record_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_first_id(input logic [15:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        id_counter = v;
    endtask

    function automatic t_in_item corners(input longint ax, input longint ay, input longint az,
                                         input longint bx, input longint by, input longint bz,
                                         input longint cx, input longint cy, input longint cz);
        t_in_item t;
        t = '0;
        t.a_x = 24'(ax); t.a_y = 24'(ay); t.a_z = 24'(az);
        t.b_x = 24'(bx); t.b_y = 24'(by); t.b_z = 24'(bz);
        t.c_x = 24'(cx); t.c_y = 24'(cy); t.c_z = 24'(cz);
        t.a_id = 16'd1; t.b_id = 16'd2; t.c_id = 16'd3;
        return t;
    endfunction

    initial begin
        t_in_item t;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = REG_FIRST_ID;
        n_errors    = 0;
        id_counter  = 16'd0;
        hold_cycles = 0;
        send_pause  = 1'b0;
        mode        = MODE_SEND_IDLE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero vector, axes, saturation, angle wrap near +-pi
        add_tri('0);
        add_tri(corners(4096, 0, 0, 0, 4096, 0, 0, 0, 4096));
        add_tri(corners(-4096, 0, 0, 0, -4096, 0, 0, 0, -4096));
        add_tri(corners(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                        8388607, -8388608, 8388607));
        add_tri(corners(-4096, 0, 10, -4096, 0, -10, -4096, 5, 1));
        add_tri(corners(-8388608, 0, 0, 0, 0, -8388608, -8388608, 8388607, 0));
        t = corners(100, -200, 300, -400, 500, -600, 700, 800, -900);
        t.a_id = 16'hFFFF; t.b_id = 16'h0000; t.c_id = 16'h8000;
        add_tri(t);
        wait_drained();

        // id wrap near the top
        write_first_id(16'hFFFE);
        repeat (3) add_tri(rand_tri());
        wait_drained();
        write_first_id(16'hFFFF);
        repeat (2) add_tri(rand_tri());
        wait_drained();
        write_first_id(16'h1234);

        // long receiver hold while the sender keeps offering
        hold_cycles = 3000;
        repeat (4) add_tri(rand_tri());
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            mode = t_mode'(ph);
            for (int n = 0; n < 80; n++) begin
                add_tri(rand_tri());
                if (n == 40) begin
                    // sender pauses until every expected record has been taken
                    send_pause = 1'b1;
                    while (record_queue.size() != 0 || in_valid) @(posedge clk);
                    send_pause = 1'b0;
                end
                while (tri_queue.size() > 3) @(posedge clk);
            end
            wait_drained();
            if (ph == 0) write_first_id(16'h0000);
            if (ph == 1) write_first_id(16'($urandom));
        end
        mode = MODE_NO_IDLE;
        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (n_errors == 0) begin
            $display("PASS spherical_triangle_subdivider_core");
        end else begin
            $display("FAIL spherical_triangle_subdivider_core");
        end
        $finish;
    end

    initial begin
        #(80_000_000);
        $display("FAIL spherical_triangle_subdivider_core");
        $finish;
    end

endmodule

// File: spherical_triangle_subdivider_core.f
rtl/core/stsub_pkg.sv
rtl/core/stsub_sqrt.sv
rtl/core/stsub_cordic.sv
rtl/core/stsub_ctrl.sv
rtl/core/stsub_dp.sv
rtl/core/spherical_triangle_subdivider_core.sv
rtl/core/stsub_checker.sv
dv/tb_spherical_triangle_subdivider_core.sv
